// File: hw/rtl/zsn_pkg.sv
// zsn_pkg: shared widths, constants and divider interface types for the
// z-score normaliser. Depends on nothing; used by zsn_div and the top level.

package zsn_pkg;

   localparam int DEPTH     = 64;
   localparam int FRAC_BITS = 16;

   localparam int SAMPLE_W = 32;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = SAMPLE_W + ADDR_W;
   localparam int SQ_W     = 2 * SAMPLE_W;
   localparam int ACC_W    = SQ_W + ADDR_W;
   localparam int ZD_W     = SAMPLE_W + FRAC_BITS;
   localparam int DEN_W    = SAMPLE_W;

   localparam int DIV_W_A  = (ACC_W > SUM_W) ? ACC_W : SUM_W;
   localparam int DIV_W    = (DIV_W_A > ZD_W) ? DIV_W_A : ZD_W;
   localparam int STEP_W   = $clog2(DIV_W + 1);

   // dividend is left-aligned in DIV_W bits, steps = number of quotient bits
   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DEN_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic             rem_nz;
   } div_rsp_type;

endpackage

// File: hw/rtl/zsn_div.sv
// zsn_div: restoring divider, one quotient bit per cycle, shared by the mean,
// variance and z-score divisions. Depends on zsn_pkg.

module zsn_div
   import zsn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   // shift the next dividend bit into the partial remainder and try it
   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         num_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;
   assign div_rsp.rem_nz   = |rem_ff;

endmodule

// File: hw/rtl/z_score_normalizer_core.sv
// Samples load at one per cycle while the core is in its load state. After the transfer
// marked last, the core runs the mean division, the deviation pass, the variance
// division and the square root. Each result then takes a buffer read and a division
// by the shared one-bit-per-cycle divider, which is skipped when the spread is zero.
// Reset is synchronous and clears control state, count, sum and overflow mark;
// the sample buffer has no reset and is only read at entries written in the set.

module z_score_normalizer_core
   import zsn_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_sample,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_original_value,
   output logic signed [SAMPLE_W-1:0] rsp_normalized_value,
   output logic signed [SAMPLE_W-1:0] rsp_mean_value,
   output logic        [SAMPLE_W-1:0] rsp_std_dev,
   output logic                       rsp_zero_spread,
   output logic                       rsp_overflowed,
   output logic                       rsp_last_result
);

   typedef enum logic [12:0] {
      ST_LOAD  = 13'b0000000000001,
      ST_MGO   = 13'b0000000000010,
      ST_MWAIT = 13'b0000000000100,
      ST_VAR   = 13'b0000000001000,
      ST_VGO   = 13'b0000000010000,
      ST_VWAIT = 13'b0000000100000,
      ST_SQRT  = 13'b0000001000000,
      ST_ZRD   = 13'b0000010000000,
      ST_ZSUB  = 13'b0000100000000,
      ST_ZGO   = 13'b0001000000000,
      ST_ZWAIT = 13'b0010000000000,
      ST_ZOUT  = 13'b0100000000000,
      ST_SPARE = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic                       ovf_ff, ovf_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       v1_ff, v1_in;
   logic                       v2_ff, v2_in;
   logic                       v3_ff, v3_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [SAMPLE_W-1:0]        m_ff, m_in;
   logic                       neg_ff, neg_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [SAMPLE_W-1:0]        mean_ff, mean_in;
   logic [SQ_W-1:0]            sqv_ff, sqv_in;
   logic [SQ_W-1:0]            res_ff, res_in;
   logic [SQ_W-1:0]            bit_ff, bit_in;
   logic [SAMPLE_W-1:0]        sd_ff, sd_in;
   logic                       zsp_ff, zsp_in;

   logic [SAMPLE_W-1:0]        out_orig_ff, out_orig_in;
   logic [SAMPLE_W-1:0]        out_z_ff, out_z_in;
   logic [SAMPLE_W-1:0]        out_mean_ff, out_mean_in;
   logic [SAMPLE_W-1:0]        out_sd_ff, out_sd_in;
   logic                       out_zsp_ff, out_zsp_in;
   logic                       out_ovf_ff, out_ovf_in;
   logic                       out_last_ff, out_last_in;

   logic [SAMPLE_W-1:0]        store_mem [DEPTH];
   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic                       mem_wr;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;

   div_req_type                div_req;
   div_rsp_type                div_rsp;

   logic                       accept;
   logic                       room;
   logic                       issue;
   logic                       out_free;
   logic [CNT_W-1:0]           idx_nxt;
   logic signed [SAMPLE_W:0]   dev;
   logic [SUM_W-1:0]           sum_abs;
   logic [SUM_W-1:0]           mean_q;
   logic [SUM_W-1:0]           mean_full;
   logic [SQ_W-1:0]            sq_prod;
   logic [SQ_W-1:0]            sqrt_t;
   logic [ZD_W-1:0]            z_q;
   logic [SAMPLE_W-1:0]        z_val;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign room     = cnt_ff < CNT_W'(DEPTH);
   assign mem_wr   = accept && room;
   assign issue    = (state_ff == ST_VAR) && (idx_ff < cnt_ff);
   assign rd_en    = issue || (state_ff == ST_ZRD);
   assign rd_addr  = idx_ff[ADDR_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_nxt  = idx_ff + CNT_W'(1);

   // buffer: written in load; read one per cycle in variance pass, once per z-score
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         store_mem[cnt_ff[ADDR_W-1:0]] <= req_sample;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   zsn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign dev     = {rd_data_ff[SAMPLE_W-1], rd_data_ff} - {mean_ff[SAMPLE_W-1], mean_ff};
   assign sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mean_q  = div_rsp.quotient[SUM_W-1:0];
   // floor division: a negative sum rounds away from zero
   assign mean_full = sum_ff[SUM_W-1] ? (~(mean_q + SUM_W'(div_rsp.rem_nz)) + SUM_W'(1))
                                      : mean_q;
   assign sq_prod = SQ_W'(m_ff) * SQ_W'(m_ff);
   assign sqrt_t  = res_ff + bit_ff;
   assign z_q     = div_rsp.quotient[ZD_W-1:0];

   always_comb begin
      if (zsp_ff) begin
         z_val = '0;
      end else if (neg_ff) begin
         if ((|z_q[ZD_W-1:SAMPLE_W]) || (z_q[SAMPLE_W-1] && (|z_q[SAMPLE_W-2:0]))) begin
            z_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
         end else begin
            z_val = ~z_q[SAMPLE_W-1:0] + SAMPLE_W'(1);
         end
      end else begin
         if (|z_q[ZD_W-1:SAMPLE_W-1]) begin
            z_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
         end else begin
            z_val = z_q[SAMPLE_W-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      sum_in       = sum_ff;
      v1_in        = issue;
      v2_in        = v1_ff;
      v3_in        = v2_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      m_in         = m_ff;
      neg_in       = neg_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      mean_in      = mean_ff;
      sqv_in       = sqv_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      sd_in        = sd_ff;
      zsp_in       = zsp_ff;
      out_orig_in  = out_orig_ff;
      out_z_in     = out_z_ff;
      out_mean_in  = out_mean_ff;
      out_sd_in    = out_sd_ff;
      out_zsp_in   = out_zsp_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      div_req      = '0;

      // deviation magnitude, shared by the variance pass and the z-score steps
      if (v1_ff || (state_ff == ST_ZSUB)) begin
         m_in   = dev[SAMPLE_W] ? SAMPLE_W'(-dev) : dev[SAMPLE_W-1:0];
         neg_in = dev[SAMPLE_W];
      end
      if (v2_ff) begin
         sq_in = sq_prod;
      end
      if (v3_ff) begin
         acc_in = acc_ff + ACC_W'(sq_ff);
      end

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  sum_in = sum_ff + SUM_W'(req_sample);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_sample) begin
                  state_in = ST_MGO;
               end
            end
         end
         ST_MGO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(sum_abs) << (DIV_W - SUM_W);
            div_req.divisor  = DEN_W'(cnt_ff);
            div_req.steps    = STEP_W'(SUM_W);
            state_in         = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (div_rsp.done) begin
               mean_in  = mean_full[SAMPLE_W-1:0];
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_VAR;
            end
         end
         ST_VAR: begin
            if (issue) begin
               idx_in = idx_nxt;
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_VGO;
            end
         end
         ST_VGO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(acc_ff) << (DIV_W - ACC_W);
            div_req.divisor  = DEN_W'(cnt_ff);
            div_req.steps    = STEP_W'(ACC_W);
            state_in         = ST_VWAIT;
         end
         ST_VWAIT: begin
            if (div_rsp.done) begin
               sqv_in   = (|div_rsp.quotient[DIV_W-1:SQ_W]) ? '1
                                                              : div_rsp.quotient[SQ_W-1:0];
               res_in   = '0;
               bit_in   = SQ_W'(1) << (SQ_W - 2);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (bit_ff != '0) begin
               if (sqv_ff >= sqrt_t) begin
                  sqv_in = sqv_ff - sqrt_t;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end else begin
               sd_in    = res_ff[SAMPLE_W-1:0];
               zsp_in   = (res_ff == '0);
               idx_in   = '0;
               state_in = ST_ZRD;
            end
         end
         ST_ZRD: begin
            state_in = ST_ZSUB;
         end
         ST_ZSUB: begin
            state_in = ST_ZGO;
         end
         ST_ZGO: begin
            if (zsp_ff) begin
               state_in = ST_ZOUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(m_ff) << (DIV_W - SAMPLE_W);
               div_req.divisor  = sd_ff;
               div_req.steps    = STEP_W'(ZD_W);
               state_in         = ST_ZWAIT;
            end
         end
         ST_ZWAIT: begin
            if (div_rsp.done) begin
               state_in = ST_ZOUT;
            end
         end
         ST_ZOUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_orig_in  = rd_data_ff;
               out_z_in     = z_val;
               out_mean_in  = mean_ff;
               out_sd_in    = sd_ff;
               out_zsp_in   = zsp_ff;
               out_ovf_in   = ovf_ff;
               out_last_in  = (idx_nxt == cnt_ff);
               if (idx_nxt == cnt_ff) begin
                  cnt_in   = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_nxt;
                  state_in = ST_ZRD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      neg_ff      <= neg_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      sqv_ff      <= sqv_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      sd_ff       <= sd_in;
      zsp_ff      <= zsp_in;
      out_orig_ff <= out_orig_in;
      out_z_ff    <= out_z_in;
      out_mean_ff <= out_mean_in;
      out_sd_ff   <= out_sd_in;
      out_zsp_ff  <= out_zsp_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_original_value   = out_orig_ff;
   assign rsp_normalized_value = out_z_ff;
   assign rsp_mean_value       = out_mean_ff;
   assign rsp_std_dev          = out_sd_ff;
   assign rsp_zero_spread      = out_zsp_ff;
   assign rsp_overflowed       = out_ovf_ff;
   assign rsp_last_result      = out_last_ff;

`ifndef SYNTHESIS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("sample count beyond buffer depth");

   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_VAR) |-> !(v1_ff || v2_ff || v3_ff))
      else $error("variance pipeline busy outside its pass");

   a_zero_spread_z: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_spread) |-> (rsp_normalized_value == '0))
      else $error("nonzero z-score with zero deviation");
`endif

endmodule
